>>> src/rrf_pkg.sv
package rrf_pkg;

    localparam int KIND_W       = 1;
    localparam int SLOT_FIELD_W = 6;
    localparam int REQ_W        = 32;
    localparam int PKT_W        = 14;
    localparam int SIZE_W       = 24;
    localparam int TYPE_W       = 8;
    localparam int ACTION_W     = 3;
    localparam int NRX_W        = 15;

    // Width used for the packet offset compares; pkt * MAX_DATA_PER_PKT + MAX_DATA_PER_PKT
    // stays below 2^29 over the whole parameter range.
    localparam int CMP_W = 32;

    localparam int DEF_NUM_SLOTS        = 64;
    localparam int DEF_REQ_WINDOW       = 8;
    localparam int DEF_MAX_DATA_PER_PKT = 1024;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RESP_Q  = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_DROP        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESEND_CR   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESEND_RESP = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MARKED      = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [REQ_W-1:0]        request_number;
        logic [PKT_W-1:0]        packet_number;
        logic [SIZE_W-1:0]       message_size;
        logic [TYPE_W-1:0]       request_type;
    } t_in;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic                    send_credit_return;
        logic                    invoke_handler;
        logic [TYPE_W-1:0]       handler_type;
        logic [SLOT_FIELD_W-1:0] out_slot;
        logic [PKT_W-1:0]        data_packet_index;
    } t_out;

    typedef struct packed {
        logic [REQ_W-1:0] cur;
        logic [NRX_W-1:0] nrx;
        logic             avail;
    } t_slot_state;

    typedef struct packed {
        logic        we;
        t_slot_state state;
    } t_upd;

endpackage

>>> src/rrf_slot_mem.sv
module rrf_slot_mem #(
    parameter int NUM_SLOTS = rrf_pkg::DEF_NUM_SLOTS,
    parameter int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output rrf_pkg::t_slot_state o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  rrf_pkg::t_slot_state i_wr_data
);

    rrf_pkg::t_slot_state r_mem [NUM_SLOTS];
    rrf_pkg::t_slot_state r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read port holds its data until the next read, so a stalled item keeps its state.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/rrf_decide.sv
module rrf_decide #(
    parameter int NUM_SLOTS        = rrf_pkg::DEF_NUM_SLOTS,
    parameter int REQ_WINDOW       = rrf_pkg::DEF_REQ_WINDOW,
    parameter int MAX_DATA_PER_PKT = rrf_pkg::DEF_MAX_DATA_PER_PKT
) (
    input  rrf_pkg::t_in         i_item,
    input  rrf_pkg::t_slot_state i_state,
    output rrf_pkg::t_out        o_result,
    output rrf_pkg::t_upd        o_upd
);

    logic                      in_range;
    logic                      single;
    logic [rrf_pkg::CMP_W-1:0] size_ext;
    logic [rrf_pkg::CMP_W-1:0] offset;
    logic [rrf_pkg::CMP_W-1:0] offset_end;
    logic                      pkt_in_msg;
    logic                      pkt_is_last;
    logic [rrf_pkg::NRX_W-1:0] pkt_ext;
    logic                      next_same;
    logic                      first_next;

    assign in_range   = 32'(i_item.slot_index) < 32'(NUM_SLOTS);
    assign size_ext   = rrf_pkg::CMP_W'(i_item.message_size);
    assign single     = size_ext <= rrf_pkg::CMP_W'(MAX_DATA_PER_PKT);

    // A packet lies inside the message when its byte offset is below the size, and it is the
    // last one when the message also ends within it.
    assign offset      = rrf_pkg::CMP_W'(i_item.packet_number)
                       * rrf_pkg::CMP_W'(MAX_DATA_PER_PKT);
    assign offset_end  = offset + rrf_pkg::CMP_W'(MAX_DATA_PER_PKT);
    assign pkt_in_msg  = offset < size_ext;
    assign pkt_is_last = pkt_in_msg && (offset_end >= size_ext);

    assign pkt_ext    = rrf_pkg::NRX_W'(i_item.packet_number);
    assign next_same  = (i_item.request_number == i_state.cur) && (pkt_ext == i_state.nrx);
    assign first_next = (i_item.request_number == i_state.cur + rrf_pkg::REQ_W'(REQ_WINDOW))
                     && (i_item.packet_number == '0);

    always_comb begin
        o_result                    = '0;
        o_result.action             = rrf_pkg::ACT_DROP;
        o_result.out_slot           = i_item.slot_index;
        o_upd.we                    = 1'b0;
        o_upd.state                 = i_state;

        if (in_range) begin
            if (i_item.kind == rrf_pkg::KIND_RESP_Q) begin
                o_upd.we          = 1'b1;
                o_upd.state.avail = 1'b1;
                o_result.action   = rrf_pkg::ACT_MARKED;
            end else if (single) begin
                if (i_item.request_number == i_state.cur) begin
                    o_result.action = i_state.avail ? rrf_pkg::ACT_RESEND_RESP
                                                    : rrf_pkg::ACT_DROP;
                end else if (i_item.request_number > i_state.cur) begin
                    o_upd.we                = 1'b1;
                    o_upd.state.avail       = 1'b0;
                    o_upd.state.cur         = i_item.request_number;
                    o_upd.state.nrx         = rrf_pkg::NRX_W'(1);
                    o_result.action         = rrf_pkg::ACT_ACCEPT;
                    o_result.invoke_handler = 1'b1;
                    o_result.handler_type   = i_item.request_type;
                end
            end else if (!(next_same || first_next)) begin
                if ((i_item.request_number != i_state.cur) || (pkt_ext > i_state.nrx)) begin
                    o_result.action = rrf_pkg::ACT_DROP;
                end else if (!pkt_is_last) begin
                    o_result.action             = rrf_pkg::ACT_RESEND_CR;
                    o_result.send_credit_return = 1'b1;
                end else begin
                    o_result.action = i_state.avail ? rrf_pkg::ACT_RESEND_RESP
                                                    : rrf_pkg::ACT_DROP;
                end
            end else if (pkt_in_msg) begin
                // In order, the new count is always the packet index plus one, so the
                // request is complete exactly on its last packet.
                o_upd.we        = 1'b1;
                o_upd.state.nrx = pkt_ext + rrf_pkg::NRX_W'(1);
                if (i_item.packet_number == '0) begin
                    o_upd.state.avail = 1'b0;
                    o_upd.state.cur   = i_item.request_number;
                end
                o_result.action             = rrf_pkg::ACT_ACCEPT;
                o_result.data_packet_index  = i_item.packet_number;
                o_result.send_credit_return = !pkt_is_last;
                if (pkt_is_last) begin
                    o_result.invoke_handler = 1'b1;
                    o_result.handler_type   = i_item.request_type;
                end
            end
        end
    end

endmodule

>>> src/rpc_request_receive_filter_top.sv
// Request receive filter: one result transfer for every input transfer, in order. After
// reset the block runs a clearing pass over all NUM_SLOTS slots that loads every slot's
// reset state, and it stalls its input during that pass. From then on it takes one item
// per cycle while the result side does not stall. The slot state is read on the edge of
// the input transfer, and the decision and state write-back happen on the edge on which
// the decision stage passes its result to the output register. The rate is set by the
// single read-modify-write per item on the slot state memory, with the last write
// forwarded to the item behind it.
module rpc_request_receive_filter_top #(
    parameter int NUM_SLOTS        = rrf_pkg::DEF_NUM_SLOTS,
    parameter int REQ_WINDOW       = rrf_pkg::DEF_REQ_WINDOW,
    parameter int MAX_DATA_PER_PKT = rrf_pkg::DEF_MAX_DATA_PER_PKT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rrf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rrf_pkg::t_out o_out_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MOD_W  = (REQ_WINDOW > 1) ? $clog2(REQ_WINDOW) : 1;

    // Clearing pass state. The modulo counter runs beside the slot counter, so the reset
    // request number of each slot needs no division.
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_idx;
    logic [MOD_W-1:0]  r_clr_mod;

    // Decision stage: the item whose slot state is being read out of memory.
    logic         r_s1_valid;
    rrf_pkg::t_in r_s1_data;

    // The most recent slot state write, forwarded to the next item when slots match.
    logic                 r_fwd_valid;
    logic [SLOT_W-1:0]    r_fwd_idx;
    rrf_pkg::t_slot_state r_fwd_state;

    logic          r_out_valid;
    rrf_pkg::t_out r_out_data;

    logic                 out_free;
    logic                 s1_fire;
    logic                 in_accept;
    logic [SLOT_W-1:0]    in_idx;
    logic [SLOT_W-1:0]    s1_idx;
    rrf_pkg::t_slot_state mem_rd_data;
    rrf_pkg::t_slot_state s1_state;
    rrf_pkg::t_slot_state clr_state;
    rrf_pkg::t_out        s1_result;
    rrf_pkg::t_upd        s1_upd;
    logic                 mem_wr_en;
    logic [SLOT_W-1:0]    mem_wr_addr;
    rrf_pkg::t_slot_state mem_wr_data;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_clearing || (r_s1_valid && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign in_idx = SLOT_W'(i_in_data.slot_index);
    assign s1_idx = SLOT_W'(r_s1_data.slot_index);

    // The memory read at transfer time misses only a write made on the same edge, and that
    // write is always the one held in the forwarding register.
    assign s1_state = (r_fwd_valid && (r_fwd_idx == s1_idx)) ? r_fwd_state : mem_rd_data;

    always_comb begin
        clr_state       = '0;
        clr_state.cur   = rrf_pkg::REQ_W'(r_clr_mod);
    end

    assign mem_wr_en   = r_clearing || (s1_fire && s1_upd.we);
    assign mem_wr_addr = r_clearing ? r_clr_idx : s1_idx;
    assign mem_wr_data = r_clearing ? clr_state : s1_upd.state;

    rrf_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .ADDR_W    (SLOT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_idx),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    rrf_decide #(
        .NUM_SLOTS        (NUM_SLOTS),
        .REQ_WINDOW       (REQ_WINDOW),
        .MAX_DATA_PER_PKT (MAX_DATA_PER_PKT)
    ) u_decide (
        .i_item   (r_s1_data),
        .i_state  (s1_state),
        .o_result (s1_result),
        .o_upd    (s1_upd)
    );

    // Clearing pass control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_clr_mod  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + SLOT_W'(1);
            if (r_clr_mod == MOD_W'(REQ_WINDOW - 1)) begin
                r_clr_mod <= '0;
            end else begin
                r_clr_mod <= r_clr_mod + MOD_W'(1);
            end
        end
    end

    // Pipeline valid bits and the forwarding marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire && s1_upd.we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
        if (s1_fire) begin
            r_out_data <= s1_result;
        end
        if (s1_fire && s1_upd.we) begin
            r_fwd_idx   <= s1_idx;
            r_fwd_state <= s1_upd.state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_data))
        else $error("decision stage item changed while stalled");

    a_no_item_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid && !r_fwd_valid)
        else $error("item in flight during clearing pass");

    a_invoke_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.invoke_handler |-> o_out_data.action == rrf_pkg::ACT_ACCEPT)
        else $error("handler invoked without accepting the packet");

    a_credit_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.send_credit_return
        |-> o_out_data.action == rrf_pkg::ACT_ACCEPT
         || o_out_data.action == rrf_pkg::ACT_RESEND_CR)
        else $error("credit return on a result that neither accepts nor resends");

    a_fwd_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_upd.we |=> r_fwd_valid && (r_fwd_idx == $past(s1_idx)))
        else $error("forwarding register missed a slot write");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS    = rrf_pkg::DEF_NUM_SLOTS;
    localparam int REQ_WINDOW   = rrf_pkg::DEF_REQ_WINDOW;
    localparam int MAX_DATA     = rrf_pkg::DEF_MAX_DATA_PER_PKT;
    localparam int REQ_W        = rrf_pkg::REQ_W;
    localparam int NRX_W        = rrf_pkg::NRX_W;
    localparam int SIZE_W       = rrf_pkg::SIZE_W;
    localparam int PKT_W        = rrf_pkg::PKT_W;
    localparam int SLOT_FIELD_W = rrf_pkg::SLOT_FIELD_W;
    localparam int TYPE_W       = rrf_pkg::TYPE_W;
    localparam int RANDOM_ITEMS = 1600;
    // Covers the clearing pass and the pipeline latency; the
    // limit is far above any run with the random gaps and stalls below.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Per-slot predictor of the filter. Each accepted header or event is run
    // through its own copy of the slot state, and the verdict it yields is
    // queued until the block returns its result transfer.
    class rpc_filter_scoreboard;
        logic [REQ_W-1:0] cur_req [NUM_SLOTS];
        logic [NRX_W-1:0] rx_count [NUM_SLOTS];
        bit               resp_ready [NUM_SLOTS];
        rrf_pkg::t_out    verdict_q [$];
        int unsigned      errors;

        function new();
            for (int s = 0; s < NUM_SLOTS; s++) begin
                cur_req[s]    = REQ_W'(s % REQ_WINDOW);
                rx_count[s]   = '0;
                resp_ready[s] = 1'b0;
            end
            errors = 0;
        endfunction

        // Packets that a request of the given size is split into.
        function logic [NRX_W-1:0] packets_for(logic [SIZE_W-1:0] size);
            logic [31:0] n;
            if (size <= SIZE_W'(MAX_DATA))
                return NRX_W'(1);
            n = (32'(size) + 32'(MAX_DATA) - 32'd1) / 32'(MAX_DATA);
            return n[NRX_W-1:0];
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        function void note_input(rrf_pkg::t_in x);
            rrf_pkg::t_out    r;
            int unsigned      s;
            logic [NRX_W-1:0] np;
            logic [NRX_W-1:0] newrx;
            logic [REQ_W-1:0] cur;
            logic [NRX_W-1:0] rx;
            bit               avail;
            bit               next_same;
            bit               first_next;
            r = '0;
            r.action = rrf_pkg::ACT_DROP;
            r.out_slot = x.slot_index;
            s = 32'(x.slot_index);
            if (s < NUM_SLOTS) begin
                cur   = cur_req[s];
                rx    = rx_count[s];
                avail = resp_ready[s];
                if (x.kind == rrf_pkg::KIND_RESP_Q) begin
                    resp_ready[s] = 1'b1;
                    r.action = rrf_pkg::ACT_MARKED;
                end else begin
                    np = packets_for(x.message_size);
                    if (np == NRX_W'(1)) begin
                        if (x.request_number < cur) begin
                            r.action = rrf_pkg::ACT_DROP;
                        end else if (x.request_number == cur) begin
                            r.action = avail ? rrf_pkg::ACT_RESEND_RESP : rrf_pkg::ACT_DROP;
                        end else begin
                            resp_ready[s] = 1'b0;
                            cur_req[s]    = x.request_number;
                            rx_count[s]   = NRX_W'(1);
                            r.action         = rrf_pkg::ACT_ACCEPT;
                            r.invoke_handler = 1'b1;
                            r.handler_type   = x.request_type;
                        end
                    end else begin
                        next_same  = (x.request_number == cur) &&
                                     (NRX_W'(x.packet_number) == rx);
                        first_next = (x.request_number == cur + REQ_W'(REQ_WINDOW)) &&
                                     (x.packet_number == '0);
                        if (!(next_same || first_next)) begin
                            // Stale packets of the current request get a credit
                            // or, for the last one, the response again if it is ready.
                            if (x.request_number != cur || NRX_W'(x.packet_number) > rx) begin
                                r.action = rrf_pkg::ACT_DROP;
                            end else if (NRX_W'(x.packet_number) != np - NRX_W'(1)) begin
                                r.action = rrf_pkg::ACT_RESEND_CR;
                                r.send_credit_return = 1'b1;
                            end else begin
                                r.action = avail ? rrf_pkg::ACT_RESEND_RESP
                                                 : rrf_pkg::ACT_DROP;
                            end
                        end else if (NRX_W'(x.packet_number) >= np) begin
                            r.action = rrf_pkg::ACT_DROP;
                        end else begin
                            if (x.packet_number == '0) begin
                                resp_ready[s] = 1'b0;
                                cur_req[s]    = x.request_number;
                                newrx         = NRX_W'(1);
                            end else begin
                                newrx = rx + NRX_W'(1);
                            end
                            rx_count[s] = newrx;
                            r.action = rrf_pkg::ACT_ACCEPT;
                            r.data_packet_index = x.packet_number;
                            if (NRX_W'(x.packet_number) != np - NRX_W'(1))
                                r.send_credit_return = 1'b1;
                            if (newrx == np) begin
                                r.invoke_handler = 1'b1;
                                r.handler_type   = x.request_type;
                            end
                        end
                    end
                end
            end
            verdict_q = {verdict_q, r};
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(rrf_pkg::t_out y);
            rrf_pkg::t_out e;
            if (verdict_q.size() == 0) begin
                $error("result for slot %0d arrived with nothing outstanding", y.out_slot);
                errors++;
                return;
            end
            e = verdict_q.pop_front();
            compare_field("action", e.action, y.action);
            compare_field("send_credit_return", e.send_credit_return, y.send_credit_return);
            compare_field("invoke_handler", e.invoke_handler, y.invoke_handler);
            compare_field("handler_type", e.handler_type, y.handler_type);
            compare_field("out_slot", e.out_slot, y.out_slot);
            compare_field("data_packet_index", e.data_packet_index, y.data_packet_index);
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    rrf_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    rrf_pkg::t_out out_data;

    // While set, neither side inserts idle cycles.
    bit          steady = 1'b0;
    int unsigned cycles = 0;

    rpc_filter_scoreboard sb;

    // Multi-packet requests that the stimulus is walking through, per slot.
    logic [REQ_W-1:0]  mp_req  [NUM_SLOTS];
    logic [SIZE_W-1:0] mp_size [NUM_SLOTS];
    int                mp_np   [NUM_SLOTS] = '{default: 0};

    always #5 clk = ~clk;

    rpc_request_receive_filter_top #(
        .NUM_SLOTS       (NUM_SLOTS),
        .REQ_WINDOW      (REQ_WINDOW),
        .MAX_DATA_PER_PKT(MAX_DATA)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // The result side stalls about a third of the time, except in the
    // steady stretch.
    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < 34);
    end

    // Every result transfer is checked against the oldest open verdict.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one header or event and returns at the edge where the transfer
    // took place, with the predictor already updated. Called at a rising edge.
    task automatic send_item(input rrf_pkg::t_in x);
        while (!steady && ($urandom_range(0, 99) < 34)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(x);
    endtask

    function automatic rrf_pkg::t_in make_item(logic k, int unsigned slot,
                                               logic [REQ_W-1:0] req,
                                               int unsigned pkt, int unsigned size,
                                               int unsigned rtype);
        rrf_pkg::t_in x;
        x.kind           = k;
        x.slot_index     = SLOT_FIELD_W'(slot);
        x.request_number = req;
        x.packet_number  = PKT_W'(pkt);
        x.message_size   = SIZE_W'(size);
        x.request_type   = TYPE_W'(rtype);
        return x;
    endfunction

    // Mostly well-formed traffic: new single-packet requests, multi-packet
    // requests walked in order with the odd retransmission, response events,
    // and some fully random headers.
    function automatic rrf_pkg::t_in random_item();
        rrf_pkg::t_in     x;
        int unsigned      s;
        int unsigned      pick;
        int unsigned      np;
        logic [NRX_W-1:0] rx;
        logic [REQ_W-1:0] cur;
        s    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_SLOTS - 1)
                                           : $urandom_range(0, 7);
        pick = $urandom_range(0, 99);
        rx   = sb.rx_count[s];
        cur  = sb.cur_req[s];
        x    = make_item(rrf_pkg::KIND_REQUEST, s, cur, 0, 0, $urandom);
        if (pick < 7) begin
            x.kind           = rrf_pkg::KIND_RESP_Q;
            x.request_number = $urandom;
            x.packet_number  = PKT_W'($urandom);
            x.message_size   = SIZE_W'($urandom);
        end else if (pick < 15) begin
            x.request_number = ($urandom_range(0, 1) == 0) ? $urandom
                                                           : cur + $urandom_range(0, 16);
            x.packet_number  = PKT_W'(($urandom_range(0, 1) == 0) ? $urandom
                                                                  : $urandom_range(0, 4));
            x.message_size   = SIZE_W'(($urandom_range(0, 1) == 0)
                                       ? $urandom : $urandom_range(0, 4 * MAX_DATA));
        end else if (mp_np[s] != 0 && cur == mp_req[s] && rx < NRX_W'(mp_np[s])) begin
            x.message_size = mp_size[s];
            if ($urandom_range(0, 99) < 80)
                x.packet_number = PKT_W'(rx);
            else
                x.packet_number = PKT_W'($urandom_range(0, rx - 1));
        end else if (pick < 55) begin
            x.message_size = SIZE_W'($urandom_range(0, MAX_DATA));
            case ($urandom_range(0, 6))
                0:       x.request_number = cur;
                1:       x.request_number = cur - $urandom_range(1, 3);
                default: x.request_number = cur + $urandom_range(1, 12);
            endcase
        end else begin
            x.request_number = cur + REQ_W'(REQ_WINDOW);
            if ($urandom_range(0, 19) == 0) begin
                // A huge request is started but never walked to its end.
                x.message_size = SIZE_W'($urandom_range(MAX_DATA + 1, (1 << SIZE_W) - 1));
            end else begin
                np = $urandom_range(2, 6);
                x.message_size = SIZE_W'((np - 1) * MAX_DATA + $urandom_range(1, MAX_DATA));
                mp_req[s]  = x.request_number;
                mp_size[s] = x.message_size;
                mp_np[s]   = np;
            end
        end
        return x;
    endfunction

    initial begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Slot s starts with current request s mod the window.
        send_item(make_item(rrf_pkg::KIND_RESP_Q, 3, 0, 0, 0, 0));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 3, 3, 0, 0, 8'h11));  // duplicate, response ready
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 5, 0, MAX_DATA, 8'h22));  // duplicate, none
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 4, 0, 1, 8'h33));  // older request
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 32'hFFFF_FFF9, 0, 1, 8'hFF));
        // Request number wraps past zero for the next multi-packet request.
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 0, MAX_DATA + 1, 8'hA5));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 0, MAX_DATA + 1, 8'hA5));  // stale, credit
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 5, MAX_DATA + 1, 8'hA5));  // ahead
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 1, MAX_DATA + 1, 8'hA5));  // completes
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 1, MAX_DATA + 1, 8'hA5));  // stale last
        send_item(make_item(rrf_pkg::KIND_RESP_Q, 5, 0, 0, 0, 0));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 1, MAX_DATA + 1, 8'hA5));  // resend
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 1, 2, 2 * MAX_DATA, 8'hA5));  // beyond
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 7, 0, 3 * MAX_DATA, 8'h5A));  // wrong req
        send_item(make_item(rrf_pkg::KIND_REQUEST, 5, 9, 1, 3 * MAX_DATA, 8'h5A));  // not pkt 0
        send_item(make_item(rrf_pkg::KIND_REQUEST, 63, 15, 0, (1 << SIZE_W) - 1, 8'h00));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 63, 15, (1 << PKT_W) - 1,
                            (1 << SIZE_W) - 1, 8'h00));
        send_item(make_item(rrf_pkg::KIND_RESP_Q, 0, 32'hFFFF_FFFF, (1 << PKT_W) - 1,
                            (1 << SIZE_W) - 1, 8'hFF));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 0, 32'hFFFF_FFFF, 0, MAX_DATA, 8'h80));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 0, 32'hFFFF_FFFF, 0, 0, 8'h80));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 62, 14, 0, 2 * MAX_DATA + 1, 8'h3C));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 62, 14, 1, 2 * MAX_DATA + 1, 8'h3C));
        send_item(make_item(rrf_pkg::KIND_REQUEST, 62, 14, 2, 2 * MAX_DATA + 1, 8'h3C));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 600 && n < 900);
            if (n == 1000) begin
                // Hold the input back until the block has drained completely.
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
